### hw/rtl/fconv_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the full linear convolution block.
// No dependencies; imported by every module of the block.
package fconv_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int TAP_W        = 16;
  localparam int PROD_W       = SAMPLE_W + TAP_W;
  localparam int VALUE_W      = 35;
  localparam int OUT_TDATA_W  = ((VALUE_W + 7) / 8) * 8;
  localparam int TCOUNT_W     = 3;
  localparam int NUM_TAPS     = 7;
  localparam int DEF_MAX_TAPS = 7;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_0     = 3'd1;

  localparam logic [TAP_W-1:0] TAP0_RESET = 16'sd32767;

  // Tag that travels with each push through the cell chain
  typedef struct packed {
    logic vld;
    logic last;
  } fconv_tag_t;

  // Front-end status seen by the top level
  typedef struct packed {
    logic flushing;
    logic take_end;
  } fconv_stat_t;

endpackage

### hw/rtl/fconv_ctrl.sv
`timescale 1ns / 1ps
// Front end: sample delay line, tail flush sequencer and push snapshot.
// Depends on fconv_pkg.
module fconv_ctrl
  import fconv_pkg::*;
#(
  parameter int MAX_TAPS = DEF_MAX_TAPS,
  parameter int TAPN_W   = $clog2(MAX_TAPS + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic signed [SAMPLE_W-1:0]         sample,
  input  logic                               block_end,
  input  logic [TAPN_W-1:0]                  n_taps,
  output fconv_tag_t                         push_tag,
  output logic [MAX_TAPS-1:0][SAMPLE_W-1:0]  push_x,
  output fconv_stat_t                        stat
);

  localparam int CNT_W = $clog2(MAX_TAPS);

  logic [MAX_TAPS-2:0][SAMPLE_W-1:0] hist;
  logic                              flushing;
  logic [CNT_W-1:0]                  remain;
  logic                              take;
  logic                              push_zero;
  logic                              single;

  // Refuse samples under reset, while the output stalls and while the tail flush runs
  assign s_tready  = adv & ~flushing & ~rst;
  assign take      = s_tvalid & s_tready;
  assign push_zero = flushing & adv;
  assign single    = (n_taps == TAPN_W'(1));

  // Snapshot: newest sample (zero during flush) then the delay line
  always_comb begin
    push_x[0] = take ? sample : '0;
    for (int k = 1; k < MAX_TAPS; k++) begin
      push_x[k] = hist[k-1];
    end
    push_tag.vld  = take | push_zero;
    push_tag.last = take ? (block_end & single) : (remain == CNT_W'(1));
  end

  assign stat.flushing = flushing;
  assign stat.take_end = take & block_end;

  // Shift the delay line on each push, clear it after the final push
  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (push_tag.vld) begin
      if (push_tag.last) begin
        hist <= '0;
      end else begin
        hist[0] <= push_x[0];
        for (int k = 1; k < MAX_TAPS - 1; k++) begin
          hist[k] <= hist[k-1];
        end
      end
    end
  end

  // Tail flush sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      flushing <= 1'b0;
      remain   <= '0;
    end else if (take) begin
      if (block_end && !single) begin
        flushing <= 1'b1;
        remain   <= CNT_W'(n_taps - TAPN_W'(1));
      end
    end else if (push_zero) begin
      remain <= remain - CNT_W'(1);
      if (remain == CNT_W'(1)) begin
        flushing <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/fconv_cell.sv
`timescale 1ns / 1ps
// One filter cell: multiplies its own tap and adds the previous product
// to the running sum handed along the chain. Depends on fconv_pkg.
module fconv_cell
  import fconv_pkg::*;
#(
  parameter int MAX_TAPS = DEF_MAX_TAPS,
  parameter int IDX      = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic signed [TAP_W-1:0]            tap,
  input  logic                               tap_en,
  input  fconv_tag_t                         in_tag,
  input  logic signed [VALUE_W-1:0]          in_psum,
  input  logic signed [PROD_W-1:0]           in_prod,
  input  logic [MAX_TAPS-1:0][SAMPLE_W-1:0]  in_x,
  output fconv_tag_t                         out_tag,
  output logic signed [VALUE_W-1:0]          out_psum,
  output logic signed [PROD_W-1:0]           out_prod,
  output logic [MAX_TAPS-1:0][SAMPLE_W-1:0]  out_x
);

  logic signed [SAMPLE_W-1:0] x_here;
  logic signed [TAP_W-1:0]    tap_eff;
  logic signed [PROD_W-1:0]   mult;

  assign x_here  = $signed(in_x[IDX]);
  assign tap_eff = tap_en ? tap : '0;
  assign mult    = x_here * tap_eff;

  // Clear the tag under reset; advance with the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag <= '0;
    end else if (adv) begin
      out_tag <= in_tag;
    end
  end

  // Payload: product of this tap, sum of all earlier taps
  always_ff @(posedge clk) begin
    if (adv) begin
      out_psum <= in_psum + VALUE_W'(in_prod);
      out_prod <= mult;
      out_x    <= in_x;
    end
  end

endmodule

### hw/rtl/full_linear_convolution.sv
`timescale 1ns / 1ps
// Top level of the full linear convolution block: configuration registers,
// front end, cell chain and output register. Depends on fconv_pkg,
// fconv_ctrl and fconv_cell.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: sample[15:0]; tlast: block_end
// m_*       out  m_tvalid/m_tready  tdata: value[34:0], zero pad; tlast: final_res
// cfg_*     in   cfg_valid/cfg_ready  cfg_index: register, cfg_data: value
//
// One sample is taken per cycle while m_* does not stall; a sample with
// tlast set is followed by n-1 zero pushes of the tail flush (n = taps in
// use), during which s_tready stays low. Each result passes through the
// chain of MAX_TAPS cells and then the output register. A stall on m_*
// freezes the whole chain and drops s_tready. Synchronous reset clears the
// delay line, the flush sequencer, the chain valids and loads the reset taps.
module full_linear_convolution
  import fconv_pkg::*;
#(
  parameter int MAX_TAPS = DEF_MAX_TAPS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [SAMPLE_W-1:0]      s_tdata,   // [15:0] sample
  input  logic                     s_tlast,   // block_end
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_TDATA_W-1:0]   m_tdata,   // [34:0] value, rest zero
  output logic                     m_tlast,   // final_res
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam int TAPN_W = $clog2(MAX_TAPS + 1);

  logic [TCOUNT_W-1:0]                  tap_count;
  logic [NUM_TAPS-1:0][TAP_W-1:0]       taps;
  logic [CFG_IDX_W-1:0]                 tap_sel;
  logic [TAPN_W-1:0]                    n_taps;
  logic [MAX_TAPS-1:0]                  tap_en;
  logic                                 adv;
  fconv_stat_t                          stat;

  fconv_tag_t                               tag  [MAX_TAPS+1];
  logic signed [VALUE_W-1:0]                psum [MAX_TAPS+1];
  logic signed [PROD_W-1:0]                 prod [MAX_TAPS+1];
  logic [MAX_TAPS-1:0][SAMPLE_W-1:0]        xv   [MAX_TAPS+1];

  logic signed [VALUE_W-1:0]                value;

  // Configuration write; refuse transfers under reset
  assign cfg_ready = ~rst;
  assign tap_sel   = cfg_index - CFG_TAP_0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= TCOUNT_W'(1);
      taps      <= '0;
      taps[0]   <= TAP0_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_TAP_COUNT) begin
        tap_count <= cfg_data[TCOUNT_W-1:0];
      end else begin
        taps[tap_sel] <= cfg_data[TAP_W-1:0];
      end
    end
  end

  // Saturate the tap count into 1..MAX_TAPS
  always_comb begin
    if (tap_count == '0) begin
      n_taps = TAPN_W'(1);
    end else if ({1'b0, tap_count} > (TCOUNT_W + 1)'(MAX_TAPS)) begin
      n_taps = TAPN_W'(MAX_TAPS);
    end else begin
      n_taps = TAPN_W'(tap_count);
    end
    for (int j = 0; j < MAX_TAPS; j++) begin
      tap_en[j] = (TAPN_W'(j) < n_taps);
    end
  end

  // Advance the chain unless a result waits at a stalled output
  assign adv = ~m_tvalid | m_tready;

  fconv_ctrl #(
    .MAX_TAPS (MAX_TAPS),
    .TAPN_W   (TAPN_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .sample    ($signed(s_tdata)),
    .block_end (s_tlast),
    .n_taps    (n_taps),
    .push_tag  (tag[0]),
    .push_x    (xv[0]),
    .stat      (stat)
  );

  assign psum[0] = '0;
  assign prod[0] = '0;

  // Chain of cells, one per tap
  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    fconv_cell #(
      .MAX_TAPS (MAX_TAPS),
      .IDX      (j)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .tap      ($signed(taps[j])),
      .tap_en   (tap_en[j]),
      .in_tag   (tag[j]),
      .in_psum  (psum[j]),
      .in_prod  (prod[j]),
      .in_x     (xv[j]),
      .out_tag  (tag[j+1]),
      .out_psum (psum[j+1]),
      .out_prod (prod[j+1]),
      .out_x    (xv[j+1])
    );
  end

  assign value = psum[MAX_TAPS] + VALUE_W'(prod[MAX_TAPS]);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= tag[MAX_TAPS].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= OUT_TDATA_W'($unsigned(value));
      m_tlast <= tag[MAX_TAPS].last;
    end
  end

  // Checks
  a_no_take_in_flush: assert property (@(posedge clk) disable iff (rst)
    stat.flushing |-> !s_tready)
    else $error("sample taken during tail flush");

  a_chain_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(tag[MAX_TAPS]) && $stable(tag[1]))
    else $error("cell chain moved while output stalled");

  a_single_tap_final: assert property (@(posedge clk) disable iff (rst)
    (stat.take_end && n_taps == TAPN_W'(1)) |=> tag[1].vld && tag[1].last)
    else $error("single-tap block end did not mark final result");

  a_flush_after_end: assert property (@(posedge clk) disable iff (rst)
    (stat.take_end && n_taps != TAPN_W'(1)) |=> stat.flushing)
    else $error("block end did not start tail flush");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for full_linear_convolution: streams sample blocks,
// predicts every output and its final flag, and compares each output transfer.
// Depends on fconv_pkg and the full_linear_convolution RTL.
module tb_top;
  import fconv_pkg::*;

  localparam int CHAIN_TAPS = DEF_MAX_TAPS;
  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               final_res;
  } conv_out_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [SAMPLE_W-1:0]    s_tdata;    // [15:0] sample
  logic                   s_tlast;    // block_end
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;    // [34:0] value, rest zero
  logic                   m_tlast;    // final_res
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Filter state mirrored from the register writes and accepted samples
  logic [TCOUNT_W-1:0]        tap_count;
  logic signed [TAP_W-1:0]    coef [NUM_TAPS];
  logic signed [SAMPLE_W-1:0] delay_line [CHAIN_TAPS-1];
  conv_out_t                  expected_outputs[$];

  bit idle_on;
  int hold_req;
  int hold_done;
  int errors;
  int n_samples;
  int n_blocks;
  int n_results;
  int n_writes;

  full_linear_convolution u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #2_000_000;
    $display("%0t timeout: %0d outputs still expected", $time, expected_outputs.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Clamp the tap count the way the block does: zero means one tap
  function automatic int active_taps();
    int n;
    n = tap_count;
    if (n < 1) n = 1;
    if (n > CHAIN_TAPS) n = CHAIN_TAPS;
    return n;
  endfunction

  // Shift one sample into the delay line and return the exact Q4.30 sum
  function automatic logic [VALUE_W-1:0] shift_and_sum(logic signed [SAMPLE_W-1:0] smp);
    longint acc;
    int     n;
    n = active_taps();
    acc = longint'(smp) * longint'(coef[0]);
    for (int j = 1; j < n; j++) acc += longint'(delay_line[j-1]) * longint'(coef[j]);
    for (int i = CHAIN_TAPS - 2; i > 0; i--) delay_line[i] = delay_line[i-1];
    delay_line[0] = smp;
    return acc[VALUE_W-1:0];
  endfunction

  // Queue the outputs of one accepted sample, tail flush included
  task automatic queue_conv_outputs(logic signed [SAMPLE_W-1:0] smp, logic blk_end);
    int        n;
    conv_out_t r;
    n = active_taps();
    r.value = shift_and_sum(smp);
    r.final_res = blk_end && (n == 1);
    expected_outputs.push_back(r);
    if (blk_end) begin
      for (int t = 1; t < n; t++) begin
        r.value = shift_and_sum('0);
        r.final_res = (t == n - 1);
        expected_outputs.push_back(r);
      end
      foreach (delay_line[i]) delay_line[i] = '0;
      n_blocks++;
    end
  endtask

  function automatic logic [15:0] rand_q15();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one sample, with an optional idle burst before it
  task automatic send_sample(logic [SAMPLE_W-1:0] smp, logic blk_end);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 5)) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= blk_end;
    do @(posedge clk); while (!s_tready);
    n_samples++;
    queue_conv_outputs(smp, blk_end);
  endtask

  // Drop valid, wait for every expected output, then let the chain settle
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (CHAIN_TAPS + 3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_TAP_COUNT) tap_count = data[TCOUNT_W-1:0];
    else coef[idx - CFG_TAP_0] = data;
    n_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all_taps(logic [TAP_W-1:0] val);
    for (int k = 0; k < NUM_TAPS; k++) write_reg(CFG_TAP_0 + CFG_IDX_W'(k), val);
  endtask

  // Random count with random upper bits, random taps
  task automatic randomize_config();
    write_reg(CFG_TAP_COUNT, {13'($urandom), 3'($urandom_range(0, 7))});
    for (int k = 0; k < NUM_TAPS; k++) write_reg(CFG_TAP_0 + CFG_IDX_W'(k), rand_q15());
  endtask

  // Random blocks of about 12 samples on average; the last one is closed only sometimes
  task automatic send_random_samples(int count);
    for (int i = 0; i < count; i++) begin
      if (i == count - 1) send_sample(rand_q15(), $urandom_range(0, 1));
      else send_sample(rand_q15(), $urandom_range(0, 11) == 0);
    end
  endtask

  // Receiver: one long hold on request, random stall bursts while idling is on, otherwise ready
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_done != hold_req) begin
        hold_done++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each output transfer with the oldest expectation
  always @(posedge clk) begin
    conv_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (expected_outputs.size() == 0) begin
        errors++;
        $display("%0t unexpected output: expected none, actual value %h last %b",
                 $time, m_tdata[VALUE_W-1:0], m_tlast);
      end else begin
        want = expected_outputs.pop_front();
        if (m_tdata[VALUE_W-1:0] !== want.value) begin
          errors++;
          $display("%0t value mismatch: expected %h, actual %h",
                   $time, want.value, m_tdata[VALUE_W-1:0]);
        end
        if (m_tlast !== want.final_res) begin
          errors++;
          $display("%0t final flag mismatch: expected %b, actual %b",
                   $time, want.final_res, m_tlast);
        end
      end
    end
  end

  // Reset taps: single tap at full scale, block of one tap ends with final set
  task automatic test_reset_defaults();
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    wait_idle();
  endtask

  // Largest positive sum with all seven taps, then negative sums from full-scale taps
  task automatic test_extreme_products();
    write_reg(CFG_TAP_COUNT, 16'hFFFF);
    write_all_taps(16'h8000);
    for (int i = 0; i < 7; i++) send_sample(16'h8000, i == 6);
    wait_idle();
    write_all_taps(16'h7FFF);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    wait_idle();
  endtask

  // A tap count of zero acts as a single tap
  task automatic test_tap_count_zero();
    write_reg(CFG_TAP_COUNT, 16'h0000);
    send_sample(16'h1234, 1'b0);
    send_sample(16'hC000, 1'b0);
    send_sample(16'h4000, 1'b1);
    wait_idle();
  endtask

  // Widen the kernel inside an open block; new taps see earlier samples
  task automatic test_count_change_mid_block();
    for (int k = 0; k < NUM_TAPS; k++) write_reg(CFG_TAP_0 + CFG_IDX_W'(k), rand_q15());
    write_reg(CFG_TAP_COUNT, 16'd2);
    send_sample(16'h2000, 1'b0);
    send_sample(16'hE000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    wait_idle();
    write_reg(CFG_TAP_COUNT, 16'd6);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0100, 1'b0);
    send_sample(16'h5555, 1'b1);
    wait_idle();
  endtask

  // Random kernels and blocks, new settings between phases
  task automatic test_random_blocks();
    for (int phase = 0; phase < 10; phase++) begin
      randomize_config();
      send_random_samples(15);
      wait_idle();
    end
  endtask

  // Long output stall while samples keep coming: the chain fills and stalls input
  task automatic test_backpressure();
    randomize_config();
    hold_req++;
    send_random_samples(20);
    wait_idle();
  endtask

  // Back-to-back transfers with no idling on either side
  task automatic test_steady_stream();
    idle_on = 1'b0;
    randomize_config();
    send_random_samples(30);
    wait_idle();
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    idle_on   = 1'b1;
    tap_count = 3'd1;
    foreach (coef[k]) coef[k] = '0;
    coef[0] = TAP0_RESET;
    foreach (delay_line[i]) delay_line[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_extreme_products();
    test_tap_count_zero();
    test_count_change_mid_block();
    test_random_blocks();
    test_backpressure();
    test_steady_stream();

    $display("Covered %0d samples in %0d closed blocks, %0d outputs checked, %0d register writes",
             n_samples, n_blocks, n_results, n_writes);
    $display("Kernels of 1 to 7 taps, extreme values, mid-block count change, long output stall");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/fconv_pkg.sv
hw/rtl/fconv_ctrl.sv
hw/rtl/fconv_cell.sv
hw/rtl/full_linear_convolution.sv
tb/tb_top.sv
